// ===== rtl/hmr_pkg.sv =====
// Shared types, widths and codes of the histogram matching remap core.
package hmr_pkg;

    // Gray levels in use and significant bits of one bin count
    localparam int LEVELS     = 256;
    localparam int COUNT_BITS = 32;

    // Storage geometry
    localparam int MAP_DEPTH  = 256;
    localparam int ADDR_BITS  = $clog2(MAP_DEPTH);
    // Level compare width: holds any 8-bit level and LEVELS itself
    localparam int LVL_BITS   = ADDR_BITS + 1;
    localparam logic [LVL_BITS-1:0] LEVELS_L = LVL_BITS'(LEVELS);

    // Field widths of the stream words
    localparam int OP_BITS    = 2;
    localparam int IDX_BITS   = 8;
    localparam int CNT_BITS   = 32;
    localparam int PIX_BITS   = 8;
    localparam int S_DATA_BITS = 48;
    localparam int M_DATA_BITS = 8;

    // A stored bin keeps COUNT_BITS bits, never more than the count field
    localparam int STORE_BITS = (COUNT_BITS < CNT_BITS) ? COUNT_BITS : CNT_BITS;
    // Cumulative counts never wrap
    localparam int CUM_BITS   = COUNT_BITS + 8;

    // Command queue between front and back
    localparam int QDEPTH     = 4;
    localparam int QADDR_BITS = $clog2(QDEPTH);

    typedef enum logic [OP_BITS-1:0] {
        OP_LOAD_SRC = 2'd0,
        OP_LOAD_TGT = 2'd1,
        OP_BUILD    = 2'd2,
        OP_REMAP    = 2'd3
    } hmr_op_t;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_BUILD = 1'b1;

    // One classified command word
    typedef struct packed {
        hmr_op_t                op;
        logic [ADDR_BITS-1:0]   idx;
        logic [STORE_BITS-1:0]  cnt;
        logic [ADDR_BITS-1:0]   pix;
    } hmr_item_t;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic valid;
    } hmr_qstat_t;

endpackage

// ===== rtl/hmr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module hmr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/hmr_front.sv =====
// Front end: accepts stream words, decodes and filters them into commands.
module hmr_front (
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [hmr_pkg::S_DATA_BITS-1:0] s_axis_tdata,
    input  logic [hmr_pkg::OP_BITS-1:0]   s_axis_tuser,
    input  hmr_pkg::hmr_qstat_t           qstat,
    output logic                          push,
    output hmr_pkg::hmr_item_t            push_item
);

    logic                             is_load;
    logic                             idx_ok;
    logic [hmr_pkg::IDX_BITS-1:0]     f_idx;
    logic [hmr_pkg::CNT_BITS-1:0]     f_cnt;
    logic [hmr_pkg::PIX_BITS-1:0]     f_pix;

    // Unpack the word fields
    assign f_idx = s_axis_tdata[hmr_pkg::IDX_BITS-1:0];
    assign f_cnt = s_axis_tdata[hmr_pkg::IDX_BITS +: hmr_pkg::CNT_BITS];
    assign f_pix = s_axis_tdata[hmr_pkg::IDX_BITS + hmr_pkg::CNT_BITS +: hmr_pkg::PIX_BITS];

    assign s_axis_tready = !qstat.full;

    // Classify: loads beyond the level range are dropped here
    always_comb begin
        is_load = (s_axis_tuser == hmr_pkg::OP_LOAD_SRC) ||
                  (s_axis_tuser == hmr_pkg::OP_LOAD_TGT);
        idx_ok  = hmr_pkg::LVL_BITS'(f_idx) < hmr_pkg::LEVELS_L;
        push    = s_axis_tvalid && s_axis_tready && (!is_load || idx_ok);
    end

    // Build the command word; counts keep only their significant bits
    always_comb begin
        push_item.op  = hmr_pkg::hmr_op_t'(s_axis_tuser);
        push_item.idx = f_idx[hmr_pkg::ADDR_BITS-1:0];
        push_item.cnt = f_cnt[hmr_pkg::STORE_BITS-1:0];
        push_item.pix = f_pix[hmr_pkg::ADDR_BITS-1:0];
    end

endmodule

// ===== rtl/hmr_queue.sv =====
// Short command queue that decouples the front end from the back end.
module hmr_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  hmr_pkg::hmr_item_t  push_item,
    input  logic                pop,
    output hmr_pkg::hmr_item_t  pop_item,
    output hmr_pkg::hmr_qstat_t qstat
);

    hmr_pkg::hmr_item_t                slots_reg [hmr_pkg::QDEPTH];
    logic [hmr_pkg::QADDR_BITS-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [hmr_pkg::QADDR_BITS-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [hmr_pkg::QADDR_BITS:0]      count_reg, count_next;

    localparam logic [hmr_pkg::QADDR_BITS-1:0] LAST_SLOT =
        hmr_pkg::QADDR_BITS'(hmr_pkg::QDEPTH - 1);
    localparam logic [hmr_pkg::QADDR_BITS:0] FULL_COUNT =
        (hmr_pkg::QADDR_BITS + 1)'(hmr_pkg::QDEPTH);

    assign qstat.full  = (count_reg == FULL_COUNT);
    assign qstat.valid = (count_reg != '0);
    assign pop_item    = slots_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/hmr_back.sv =====
// Back end: executes loads, walks the bins to build the map, remaps pixels.
module hmr_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  hmr_pkg::hmr_qstat_t             qstat,
    input  hmr_pkg::hmr_item_t              q_item,
    output logic                            pop,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [hmr_pkg::PIX_BITS-1:0]    m_pixel,
    output logic                            m_kind
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT_RD,
        S_INIT_ADD,
        S_SRC_RD,
        S_SRC_ADD,
        S_TGT_RD,
        S_TGT_ADD,
        S_CMP,
        S_DONE
    } state_t;

    localparam logic [hmr_pkg::ADDR_BITS-1:0] LAST_LEVEL =
        hmr_pkg::ADDR_BITS'(hmr_pkg::LEVELS - 1);

    state_t                              state_reg, state_next;
    logic [hmr_pkg::ADDR_BITS-1:0]       i_reg, i_next;
    logic [hmr_pkg::LVL_BITS-1:0]        z_reg, z_next;
    logic [hmr_pkg::CUM_BITS-1:0]        src_cum_reg, src_cum_next;
    logic [hmr_pkg::CUM_BITS-1:0]        tgt_cum_reg, tgt_cum_next;
    logic                                map_valid_reg, map_valid_next;
    logic                                s1_valid_reg, s1_valid_next;
    logic                                s1_kind_reg, s1_kind_next;
    logic                                s1_zero_reg, s1_zero_next;
    logic                                out_valid_reg, out_valid_next;
    logic                                out_kind_reg, out_kind_next;
    logic [hmr_pkg::PIX_BITS-1:0]        out_pixel_reg, out_pixel_next;

    logic                                advance;
    logic                                is_load;
    logic                                z_in_range;
    logic [hmr_pkg::LVL_BITS-1:0]        z_inc;

    logic                                src_we, tgt_we, src_re, tgt_re;
    logic                                map_we, map_re;
    logic [hmr_pkg::STORE_BITS-1:0]      src_rdata, tgt_rdata;
    logic [hmr_pkg::PIX_BITS-1:0]        map_wdata, map_rdata;

    // Histogram and level map stores
    hmr_ram #(.WIDTH(hmr_pkg::STORE_BITS), .DEPTH(hmr_pkg::MAP_DEPTH)) u_src_ram (
        .aclk    (aclk),
        .wr_en   (src_we),
        .wr_addr (q_item.idx),
        .wr_data (q_item.cnt),
        .rd_en   (src_re),
        .rd_addr (i_reg),
        .rd_data (src_rdata)
    );

    hmr_ram #(.WIDTH(hmr_pkg::STORE_BITS), .DEPTH(hmr_pkg::MAP_DEPTH)) u_tgt_ram (
        .aclk    (aclk),
        .wr_en   (tgt_we),
        .wr_addr (q_item.idx),
        .wr_data (q_item.cnt),
        .rd_en   (tgt_re),
        .rd_addr (z_reg[hmr_pkg::ADDR_BITS-1:0]),
        .rd_data (tgt_rdata)
    );

    hmr_ram #(.WIDTH(hmr_pkg::PIX_BITS), .DEPTH(hmr_pkg::MAP_DEPTH)) u_map_ram (
        .aclk    (aclk),
        .wr_en   (map_we),
        .wr_addr (i_reg),
        .wr_data (map_wdata),
        .rd_en   (map_re),
        .rd_addr (q_item.pix),
        .rd_data (map_rdata)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_pixel       = out_pixel_reg;
    assign m_kind        = out_kind_reg;

    // Issue commands, walk the bins, move results down the output pipe
    always_comb begin
        advance    = !out_valid_reg || m_axis_tready;
        is_load    = (q_item.op == hmr_pkg::OP_LOAD_SRC) ||
                     (q_item.op == hmr_pkg::OP_LOAD_TGT);
        z_in_range = z_reg < hmr_pkg::LEVELS_L;
        z_inc      = z_reg + 1'b1;
        map_wdata  = z_in_range ? z_reg[hmr_pkg::PIX_BITS-1:0] : '0;

        pop = (state_reg == S_IDLE) && qstat.valid &&
              (is_load || !s1_valid_reg || advance);

        src_we = pop && (q_item.op == hmr_pkg::OP_LOAD_SRC);
        tgt_we = pop && (q_item.op == hmr_pkg::OP_LOAD_TGT);
        map_re = pop && (q_item.op == hmr_pkg::OP_REMAP);
        src_re = (state_reg == S_INIT_RD) || (state_reg == S_SRC_RD);
        tgt_re = (state_reg == S_INIT_RD) || (state_reg == S_TGT_RD);
        map_we = 1'b0;

        state_next     = state_reg;
        i_next         = i_reg;
        z_next         = z_reg;
        src_cum_next   = src_cum_reg;
        tgt_cum_next   = tgt_cum_reg;
        map_valid_next = map_valid_reg;
        s1_valid_next  = s1_valid_reg;
        s1_kind_next   = s1_kind_reg;
        s1_zero_next   = s1_zero_reg;

        // Drain the read stage into the output register
        if (advance) begin
            s1_valid_next  = 1'b0;
            out_valid_next = s1_valid_reg;
            out_kind_next  = s1_kind_reg;
            out_pixel_next = s1_zero_reg ? '0 : map_rdata;
        end else begin
            out_valid_next = out_valid_reg;
            out_kind_next  = out_kind_reg;
            out_pixel_next = out_pixel_reg;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (map_re) begin
                    s1_valid_next = 1'b1;
                    s1_kind_next  = hmr_pkg::KIND_PIXEL;
                    s1_zero_next  = !map_valid_reg ||
                                    !(hmr_pkg::LVL_BITS'(q_item.pix) < hmr_pkg::LEVELS_L);
                end else if (pop && (q_item.op == hmr_pkg::OP_BUILD)) begin
                    i_next     = '0;
                    z_next     = '0;
                    state_next = S_INIT_RD;
                end
            end
            S_INIT_RD: begin
                state_next = S_INIT_ADD;
            end
            S_INIT_ADD: begin
                src_cum_next = hmr_pkg::CUM_BITS'(src_rdata);
                tgt_cum_next = hmr_pkg::CUM_BITS'(tgt_rdata);
                state_next   = S_CMP;
            end
            S_SRC_RD: begin
                state_next = S_SRC_ADD;
            end
            S_SRC_ADD: begin
                src_cum_next = src_cum_reg + hmr_pkg::CUM_BITS'(src_rdata);
                state_next   = S_CMP;
            end
            S_TGT_RD: begin
                state_next = S_TGT_ADD;
            end
            S_TGT_ADD: begin
                tgt_cum_next = tgt_cum_reg + hmr_pkg::CUM_BITS'(tgt_rdata);
                state_next   = S_CMP;
            end
            S_CMP: begin
                // Move the target pointer forward, or settle this level
                if (z_in_range && (tgt_cum_reg < src_cum_reg)) begin
                    z_next     = z_inc;
                    state_next = (z_inc < hmr_pkg::LEVELS_L) ? S_TGT_RD : S_CMP;
                end else begin
                    map_we = 1'b1;
                    if (i_reg == LAST_LEVEL) begin
                        state_next = S_DONE;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_SRC_RD;
                    end
                end
            end
            S_DONE: begin
                // Report the finished build once the read stage is free
                if (!s1_valid_reg || advance) begin
                    s1_valid_next  = 1'b1;
                    s1_kind_next   = hmr_pkg::KIND_BUILD;
                    s1_zero_next   = 1'b1;
                    map_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            map_valid_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            z_reg         <= '0;
        end else begin
            state_reg     <= state_next;
            map_valid_reg <= map_valid_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            i_reg         <= i_next;
            z_reg         <= z_next;
            src_cum_reg   <= src_cum_next;
            tgt_cum_reg   <= tgt_cum_next;
            s1_kind_reg   <= s1_kind_next;
            s1_zero_reg   <= s1_zero_next;
            out_kind_reg  <= out_kind_next;
            out_pixel_reg <= out_pixel_next;
        end
    end

`ifndef ASSERT_OFF
    // Target pointer never runs past one beyond the last level
    a_z_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        z_reg <= hmr_pkg::LEVELS_L)
        else $error("target pointer out of range");

    // Map is never written and read in the same cycle
    a_map_port: assert property (@(posedge aclk) disable iff (!aresetn)
        !(map_we && map_re))
        else $error("map write collides with remap read");

    // Leaving the done state queues a build report and marks the map built
    a_done_report: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && (!s1_valid_reg || advance)) |=>
        (map_valid_reg && s1_valid_reg && s1_kind_reg == hmr_pkg::KIND_BUILD &&
         state_reg == S_IDLE))
        else $error("build completion not reported");

    // A build report always carries a zero level
    a_build_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_kind_reg == hmr_pkg::KIND_BUILD) |-> (out_pixel_reg == '0))
        else $error("build report with nonzero level");
`endif

endmodule

// ===== rtl/histogram_matching_remap_core.sv =====
// Top level of the histogram matching remap core: front, queue and back.
//
//  channel   dir  tdata (low bit up)                          tuser
//  s_axis    in   bin_index[7:0] bin_count[39:8] pixel_in[47:40]  operation[1:0]
//  m_axis    out  pixel_out[7:0]                              result_kind[0]
//
// Loads and remaps run at one word per cycle while no build is running and the
// output is not stalled; a remap result passes through the queue slot, the map
// read and the output register. A build walks both histograms through single
// read ports: each source level and each target step passes through a read
// state, an add state and the compare state. After reset the map reads as zero
// until the first build; there is no clearing pass. A four-word command queue
// and a two-deep output pipe let input and output stall independently.
module histogram_matching_remap_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // bin_index [7:0], bin_count [39:8], pixel_in [47:40]
    input  logic [hmr_pkg::S_DATA_BITS-1:0]   s_axis_tdata,
    // operation [1:0]
    input  logic [hmr_pkg::OP_BITS-1:0]       s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // pixel_out [7:0]
    output logic [hmr_pkg::M_DATA_BITS-1:0]   m_axis_tdata,
    // result_kind [0]
    output logic [0:0]                        m_axis_tuser
);

    hmr_pkg::hmr_qstat_t             qstat;
    hmr_pkg::hmr_item_t              push_item, pop_item;
    logic                            push, pop;
    logic [hmr_pkg::PIX_BITS-1:0]    m_pixel;
    logic                            m_kind;

    hmr_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .qstat         (qstat),
        .push          (push),
        .push_item     (push_item)
    );

    hmr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .qstat     (qstat)
    );

    hmr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .qstat         (qstat),
        .q_item        (pop_item),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_pixel       (m_pixel),
        .m_kind        (m_kind)
    );

    // Pack the result word
    assign m_axis_tdata = hmr_pkg::M_DATA_BITS'(m_pixel);
    assign m_axis_tuser = m_kind;

endmodule

// ===== test/histogram_matching_remap_core_tb.sv =====
// Self-checking testbench for the histogram matching remap core.
module histogram_matching_remap_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no word moving on either side before the run is abandoned
    localparam int STALL_LIMIT = 20000;
    localparam int ITEM_TARGET = 1350;
    localparam int LONG_HOLD   = 400;

    // One expected output word
    typedef struct packed {
        logic                           kind;
        logic [hmr_pkg::PIX_BITS-1:0]   level;
    } remap_result_t;

    // Tracks both histograms and the level map, and queues the words that
    // the core must return, in order.
    class remap_scoreboard;
        logic [hmr_pkg::CNT_BITS-1:0] src_bins [hmr_pkg::MAP_DEPTH];
        logic [hmr_pkg::CNT_BITS-1:0] tgt_bins [hmr_pkg::MAP_DEPTH];
        logic [hmr_pkg::PIX_BITS-1:0] level_map [hmr_pkg::MAP_DEPTH];
        remap_result_t                expected_q [$];
        int                           errors;

        function new();
            foreach (level_map[i]) begin
                level_map[i] = '0;
                src_bins[i]  = '0;
                tgt_bins[i]  = '0;
            end
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Match every source level to the first target level whose running
        // count reaches the source running count; fall back to level zero.
        function void rebuild_map();
            logic [hmr_pkg::CUM_BITS-1:0] tgt_cum [hmr_pkg::MAP_DEPTH];
            logic [hmr_pkg::CUM_BITS-1:0] acc;
            logic [hmr_pkg::CUM_BITS-1:0] src_cum;
            int                           span;
            int                           z;
            span = (hmr_pkg::LEVELS > hmr_pkg::MAP_DEPTH) ? hmr_pkg::MAP_DEPTH
                                                          : hmr_pkg::LEVELS;
            acc = '0;
            for (int i = 0; i < span; i++) begin
                acc += hmr_pkg::CUM_BITS'(tgt_bins[i]);
                tgt_cum[i] = acc;
            end
            src_cum = '0;
            z = 0;
            for (int i = 0; i < span; i++) begin
                src_cum += hmr_pkg::CUM_BITS'(src_bins[i]);
                while (z < span && tgt_cum[z] < src_cum)
                    z++;
                level_map[i] = (z < span) ? hmr_pkg::PIX_BITS'(z) : '0;
            end
        endfunction

        // Apply one accepted input word and queue any word it produces
        function void note_input(hmr_pkg::hmr_op_t op,
                                 logic [hmr_pkg::S_DATA_BITS-1:0] word);
            logic [hmr_pkg::IDX_BITS-1:0] idx;
            logic [hmr_pkg::CNT_BITS-1:0] cnt;
            logic [hmr_pkg::PIX_BITS-1:0] pix;
            remap_result_t                res;
            idx = word[7:0];
            cnt = hmr_pkg::CNT_BITS'(40'(word[39:8]) &
                                     ((40'd1 << hmr_pkg::COUNT_BITS) - 40'd1));
            pix = word[47:40];
            case (op)
                hmr_pkg::OP_LOAD_SRC: begin
                    if (idx < hmr_pkg::LEVELS) src_bins[idx] = cnt;
                end
                hmr_pkg::OP_LOAD_TGT: begin
                    if (idx < hmr_pkg::LEVELS) tgt_bins[idx] = cnt;
                end
                hmr_pkg::OP_BUILD: begin
                    rebuild_map();
                    res.kind  = hmr_pkg::KIND_BUILD;
                    res.level = '0;
                    expected_q.push_back(res);
                end
                default: begin
                    res.kind  = hmr_pkg::KIND_PIXEL;
                    res.level = level_map[pix];
                    expected_q.push_back(res);
                end
            endcase
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 50) $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        task check_result(logic kind, logic [hmr_pkg::PIX_BITS-1:0] level);
            remap_result_t exp_r;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word kind=%0d pixel=%0d", kind, level));
                return;
            end
            exp_r = expected_q.pop_front();
            if (kind !== exp_r.kind)
                report_mismatch($sformatf("kind %0d, want %0d", kind, exp_r.kind));
            if (level !== exp_r.level)
                report_mismatch($sformatf("pixel %0d, want %0d (kind %0d)",
                                          level, exp_r.level, exp_r.kind));
        endtask
    endclass

    logic                               aclk;
    logic                               aresetn;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [hmr_pkg::S_DATA_BITS-1:0]    s_axis_tdata;
    logic [hmr_pkg::OP_BITS-1:0]        s_axis_tuser;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    logic [hmr_pkg::M_DATA_BITS-1:0]    m_axis_tdata;
    logic [0:0]                         m_axis_tuser;

    remap_scoreboard book;
    int   items_sent;
    int   quiet_cycles = 0;
    logic sender_calm;
    logic hold_request;

    histogram_matching_remap_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [hmr_pkg::CNT_BITS-1:0] draw_count(int mode);
        case (mode)
            0:       return ($urandom_range(0, 1) == 0) ? '0 : $urandom_range(0, 50);
            1:       return $urandom_range(0, 255);
            2:       return $urandom();
            default: return $urandom() | 32'hFFFF_0000;
        endcase
    endfunction

    // Random filler for a bin index or a pixel field
    function automatic logic [hmr_pkg::PIX_BITS-1:0] draw_byte();
        return hmr_pkg::PIX_BITS'($urandom());
    endfunction

    function automatic logic [hmr_pkg::PIX_BITS-1:0] draw_pixel();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return hmr_pkg::PIX_BITS'($urandom_range(0, 255));
    endfunction

    // Offer one word from a falling edge and hold it until taken
    task automatic send_word(input hmr_pkg::hmr_op_t op,
                             input logic [hmr_pkg::IDX_BITS-1:0] idx,
                             input logic [hmr_pkg::CNT_BITS-1:0] cnt,
                             input logic [hmr_pkg::PIX_BITS-1:0] pix);
        int gap;
        gap = sender_calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {pix, cnt, idx};
        s_axis_tuser  = op;
        do @(posedge aclk); while (!s_axis_tready);
        book.note_input(op, {pix, cnt, idx});
        items_sent++;
        @(negedge aclk);
    endtask

    // Check every word the core hands over
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_axis_tvalid && m_axis_tready) begin
            book.check_result(m_axis_tuser[0], m_axis_tdata);
        end
    end

    // Abandon the run when nothing moves for too long
    always @(posedge aclk) begin
        if (aresetn !== 1'b1 || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Output side: random stalls, calm stretches and one long hold
    initial begin : result_sink
        int stall_left;
        int calm_left;
        int r;
        logic held_done;
        stall_left = 0;
        calm_left  = 0;
        held_done  = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request && !held_done) begin
                m_axis_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                held_done = 1'b1;
            end
            if (stall_left > 0) begin
                m_axis_tready = 1'b0;
                stall_left--;
            end else begin
                m_axis_tready = 1'b1;
                if (calm_left > 0) begin
                    calm_left--;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 30) stall_left = pick_gap();
                    else if (r < 33) calm_left = $urandom_range(50, 200);
                end
            end
        end
    end

    // Input side: directed opening, then random phases
    initial begin : stimulus
        int phase;
        int n;
        int mode;
        int r;
        logic [hmr_pkg::CNT_BITS-1:0] cnt;
        hmr_pkg::hmr_op_t             load_op;
        book = new();
        items_sent    = 0;
        sender_calm   = 1'b0;
        hold_request  = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = hmr_pkg::OP_LOAD_SRC;
        aresetn       = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Remap before any build reads the reset map
        send_word(hmr_pkg::OP_REMAP, draw_byte(), $urandom(), 8'd0);
        send_word(hmr_pkg::OP_REMAP, draw_byte(), $urandom(), 8'd255);

        // Fill every bin once; the source total beats the target total so
        // the top level finds no target level and falls back to zero, and the
        // all-ones counts push the running sums past 32 bits.
        for (int i = 0; i < hmr_pkg::LEVELS; i++) begin
            if (i == 0) cnt = '0;
            else if (i == hmr_pkg::LEVELS - 1) cnt = '1;
            else cnt = $urandom_range(0, 1000);
            send_word(hmr_pkg::OP_LOAD_SRC, hmr_pkg::IDX_BITS'(i), cnt, draw_byte());
        end
        for (int i = 0; i < hmr_pkg::LEVELS; i++) begin
            if (i == hmr_pkg::LEVELS / 2) cnt = '1;
            else if (i % 2 == 0) cnt = $urandom_range(0, 500);
            else cnt = '0;
            send_word(hmr_pkg::OP_LOAD_TGT, hmr_pkg::IDX_BITS'(i), cnt, draw_byte());
        end
        send_word(hmr_pkg::OP_BUILD, draw_byte(), $urandom(), draw_byte());
        send_word(hmr_pkg::OP_REMAP, draw_byte(), $urandom(), 8'd0);
        send_word(hmr_pkg::OP_REMAP, draw_byte(), $urandom(), 8'd255);
        send_word(hmr_pkg::OP_REMAP, draw_byte(), $urandom(), 8'd128);
        send_word(hmr_pkg::OP_REMAP, draw_byte(), $urandom(), 8'd1);
        send_word(hmr_pkg::OP_BUILD, draw_byte(), $urandom(), draw_byte());
        send_word(hmr_pkg::OP_REMAP, draw_byte(), $urandom(), 8'd254);

        // Random phases: rewrite some bins, rebuild, then a remap-heavy mix
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            if (phase == 2) begin
                s_axis_tvalid = 1'b0;
                while (book.pending() != 0) @(negedge aclk);
            end
            sender_calm = (phase == 1) || ($urandom_range(0, 3) == 0);
            mode = $urandom_range(0, 3);
            n = $urandom_range(0, 60);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 1) != 0) load_op = hmr_pkg::OP_LOAD_TGT;
                else load_op = hmr_pkg::OP_LOAD_SRC;
                send_word(load_op, draw_byte(), draw_count(mode), draw_byte());
            end
            send_word(hmr_pkg::OP_BUILD, draw_byte(), $urandom(), draw_byte());
            if (phase == 1) hold_request = 1'b1;
            n = $urandom_range(30, 100);
            for (int i = 0; i < n; i++) begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    send_word(hmr_pkg::OP_REMAP, draw_byte(), $urandom(), draw_pixel());
                else if (r < 90)
                    send_word(hmr_pkg::OP_LOAD_SRC, draw_byte(), draw_count(mode),
                              draw_byte());
                else if (r < 97)
                    send_word(hmr_pkg::OP_LOAD_TGT, draw_byte(), draw_count(mode),
                              draw_byte());
                else
                    send_word(hmr_pkg::OP_BUILD, draw_byte(), $urandom(), draw_byte());
            end
            phase++;
        end
        s_axis_tvalid = 1'b0;

        // Drain, then let the pipeline settle
        while (book.pending() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (book.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/hmr_pkg.sv
rtl/hmr_ram.sv
rtl/hmr_front.sv
rtl/hmr_queue.sv
rtl/hmr_back.sv
rtl/histogram_matching_remap_core.sv
test/histogram_matching_remap_core_tb.sv
